// File: rtl/lzss_pkg.sv
`default_nettype none
package lzss_pkg;

  localparam int unsigned DICT_SIZE_DEF   = 8192;
  localparam int unsigned LENGTH_BITS_DEF = 4;
  localparam int unsigned BREAKEVEN       = 3;

  localparam logic [1:0] MODE_WRITE  = 2'd0;
  localparam logic [1:0] MODE_ROOT   = 2'd1;
  localparam logic [1:0] MODE_INSERT = 2'd2;
  localparam logic [1:0] MODE_DELETE = 2'd3;

  localparam int unsigned SW = 5;

  localparam logic [SW-1:0] ST_IDLE  = 5'd0;
  localparam logic [SW-1:0] ST_CLR   = 5'd1;
  localparam logic [SW-1:0] ST_DISP  = 5'd2;
  localparam logic [SW-1:0] ST_WRB   = 5'd3;
  localparam logic [SW-1:0] ST_ROOTA = 5'd4;
  localparam logic [SW-1:0] ST_ROOTB = 5'd5;
  localparam logic [SW-1:0] ST_INS0  = 5'd6;
  localparam logic [SW-1:0] ST_INS1  = 5'd7;
  localparam logic [SW-1:0] ST_CRD   = 5'd8;
  localparam logic [SW-1:0] ST_CCMP  = 5'd9;
  localparam logic [SW-1:0] ST_CEVAL = 5'd10;
  localparam logic [SW-1:0] ST_LNKA  = 5'd11;
  localparam logic [SW-1:0] ST_LNKB  = 5'd12;
  localparam logic [SW-1:0] ST_P0    = 5'd13;
  localparam logic [SW-1:0] ST_P1    = 5'd14;
  localparam logic [SW-1:0] ST_P2    = 5'd15;
  localparam logic [SW-1:0] ST_P3    = 5'd16;
  localparam logic [SW-1:0] ST_P4    = 5'd17;
  localparam logic [SW-1:0] ST_P5    = 5'd18;
  localparam logic [SW-1:0] ST_P6    = 5'd19;
  localparam logic [SW-1:0] ST_P7    = 5'd20;
  localparam logic [SW-1:0] ST_DEL0  = 5'd21;
  localparam logic [SW-1:0] ST_DEL1  = 5'd22;
  localparam logic [SW-1:0] ST_S1    = 5'd23;
  localparam logic [SW-1:0] ST_S2    = 5'd24;
  localparam logic [SW-1:0] ST_S3    = 5'd25;
  localparam logic [SW-1:0] ST_Q0    = 5'd26;
  localparam logic [SW-1:0] ST_Q1    = 5'd27;
  localparam logic [SW-1:0] ST_DONE  = 5'd28;

  typedef struct packed {
    logic [SW-1:0] uop;
    logic          load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       y_zero;
    logic       cmp_done;
    logic       full;
    logic       slot_zero;
    logic       cnt_end;
    logic       lp_zero;
    logic       ll_zero;
    logic       lr_zero;
    logic       sub;
    logic       pred_more;
    logic       out_busy;
  } status_t;

endpackage
`default_nettype wire

// File: rtl/lzss_tree_match_finder.sv
`default_nettype none
// Channel   Dir  Handshake           Payload
// s_*       in   s_tvalid/s_tready   tuser: mode; tdata: position, byte_value
// m_*       out  m_tvalid/m_tready   tdata: match_length, match_position
//
// One request at a time. Delete leaves an unlinked position as it is, splices out a
// node with one child, or moves the predecessor into a node with two children. Insert
// walks the tree, then links the new node, or replaces the node on a full-length
// match; at position zero it skips the tree. The dictionary compares one byte a cycle.
// After reset a clearing pass zeroes the dictionary and links.
// The result register holds while m_tready is low; a finished request waits for it.
module lzss_tree_match_finder #(
  parameter int unsigned DICT_SIZE   = lzss_pkg::DICT_SIZE_DEF,
  parameter int unsigned LENGTH_BITS = lzss_pkg::LENGTH_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_tvalid_i,
  output logic             s_tready_o,
  input  wire logic [23:0] s_tdata_i,   // position[12:0], byte_value[20:13], zero
  input  wire logic [1:0]  s_tuser_i,   // mode[1:0]
  output logic             m_tvalid_o,
  input  wire logic        m_tready_i,
  output logic [23:0]      m_tdata_o    // match_length[4:0], match_position[17:5], zero
);

  lzss_pkg::cmd_t    cmd;
  lzss_pkg::status_t st;
  logic [4:0]        mlen;
  logic [12:0]       mpos;

  lzss_ctrl u_ctrl (
    .clk_i, .rst_ni, .s_tvalid_i, .s_tready_o, .st_i(st), .cmd_o(cmd)
  );

  lzss_datapath #(.DICT_SIZE(DICT_SIZE), .LENGTH_BITS(LENGTH_BITS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd),
    .mode_i(s_tuser_i), .position_i(s_tdata_i[12:0]), .byte_value_i(s_tdata_i[20:13]),
    .st_o(st), .m_tvalid_o, .m_tready_i,
    .match_length_o(mlen), .match_position_o(mpos)
  );

  assign m_tdata_o = {6'd0, mpos, mlen};

endmodule
`default_nettype wire

// File: rtl/lzss_ram.sv
`default_nettype none
module lzss_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// File: rtl/lzss_ctrl.sv
`default_nettype none
module lzss_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_tvalid_i,
  output logic                  s_tready_o,
  input  wire lzss_pkg::status_t st_i,
  output lzss_pkg::cmd_t        cmd_o
);

  logic [lzss_pkg::SW-1:0] state_q, state_d;

  assign s_tready_o = (state_q == lzss_pkg::ST_IDLE);
  assign cmd_o.uop  = state_q;
  assign cmd_o.load = s_tready_o && s_tvalid_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      lzss_pkg::ST_IDLE:  if (s_tvalid_i) state_d = lzss_pkg::ST_DISP;
      lzss_pkg::ST_CLR:   if (st_i.cnt_end) state_d = lzss_pkg::ST_IDLE;
      lzss_pkg::ST_DISP: begin
        case (st_i.mode)
          lzss_pkg::MODE_WRITE:  state_d = lzss_pkg::ST_WRB;
          lzss_pkg::MODE_ROOT:   state_d = lzss_pkg::ST_ROOTA;
          lzss_pkg::MODE_INSERT: state_d = st_i.y_zero ? lzss_pkg::ST_DONE : lzss_pkg::ST_INS0;
          default:               state_d = lzss_pkg::ST_DEL0;
        endcase
      end
      lzss_pkg::ST_WRB:   state_d = lzss_pkg::ST_DONE;
      lzss_pkg::ST_ROOTA: state_d = lzss_pkg::ST_ROOTB;
      lzss_pkg::ST_ROOTB: state_d = lzss_pkg::ST_DONE;
      lzss_pkg::ST_INS0:  state_d = lzss_pkg::ST_INS1;
      lzss_pkg::ST_INS1:  state_d = lzss_pkg::ST_CRD;
      lzss_pkg::ST_CRD:   state_d = lzss_pkg::ST_CCMP;
      lzss_pkg::ST_CCMP:  if (st_i.cmp_done) state_d = lzss_pkg::ST_CEVAL;
      lzss_pkg::ST_CEVAL: begin
        if (st_i.full) state_d = lzss_pkg::ST_P0;
        else if (st_i.slot_zero) state_d = lzss_pkg::ST_LNKA;
        else if (st_i.cnt_end) state_d = lzss_pkg::ST_DONE;
        else state_d = lzss_pkg::ST_CRD;
      end
      lzss_pkg::ST_LNKA:  state_d = lzss_pkg::ST_LNKB;
      lzss_pkg::ST_LNKB:  state_d = lzss_pkg::ST_DONE;
      lzss_pkg::ST_P0:    state_d = lzss_pkg::ST_P1;
      lzss_pkg::ST_P1:    state_d = lzss_pkg::ST_P2;
      lzss_pkg::ST_P2:    state_d = lzss_pkg::ST_P3;
      lzss_pkg::ST_P3:    state_d = lzss_pkg::ST_P4;
      lzss_pkg::ST_P4:    state_d = lzss_pkg::ST_P5;
      lzss_pkg::ST_P5:    state_d = lzss_pkg::ST_P6;
      lzss_pkg::ST_P6:    state_d = lzss_pkg::ST_P7;
      lzss_pkg::ST_P7:    state_d = lzss_pkg::ST_DONE;
      lzss_pkg::ST_DEL0:  state_d = lzss_pkg::ST_DEL1;
      lzss_pkg::ST_DEL1: begin
        if (st_i.lp_zero) state_d = st_i.sub ? lzss_pkg::ST_P0 : lzss_pkg::ST_DONE;
        else if (st_i.lr_zero || st_i.ll_zero) state_d = lzss_pkg::ST_S1;
        else state_d = st_i.sub ? lzss_pkg::ST_P0 : lzss_pkg::ST_Q0;
      end
      lzss_pkg::ST_S1:    state_d = lzss_pkg::ST_S2;
      lzss_pkg::ST_S2:    state_d = lzss_pkg::ST_S3;
      lzss_pkg::ST_S3:    state_d = st_i.sub ? lzss_pkg::ST_P0 : lzss_pkg::ST_DONE;
      lzss_pkg::ST_Q0:    state_d = lzss_pkg::ST_Q1;
      lzss_pkg::ST_Q1:    if (!st_i.pred_more) state_d = lzss_pkg::ST_DEL0;
      lzss_pkg::ST_DONE:  if (!st_i.out_busy) state_d = lzss_pkg::ST_IDLE;
      default:            state_d = lzss_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lzss_pkg::ST_CLR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

// File: rtl/lzss_datapath.sv
`default_nettype none
module lzss_datapath #(
  parameter int unsigned DICT_SIZE   = lzss_pkg::DICT_SIZE_DEF,
  parameter int unsigned LENGTH_BITS = lzss_pkg::LENGTH_BITS_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire lzss_pkg::cmd_t   cmd_i,
  input  wire logic [1:0]       mode_i,
  input  wire logic [12:0]      position_i,
  input  wire logic [7:0]       byte_value_i,
  output lzss_pkg::status_t     st_o,
  output logic                  m_tvalid_o,
  input  wire logic             m_tready_i,
  output logic [4:0]            match_length_o,
  output logic [12:0]           match_position_o
);

  localparam int unsigned AW        = $clog2(DICT_SIZE);
  localparam int unsigned PW        = $clog2(DICT_SIZE + 1);
  localparam int unsigned MATCH_MAX = (1 << LENGTH_BITS) + lzss_pkg::BREAKEVEN - 1;
  localparam int unsigned IW        = $clog2(MATCH_MAX + 1);
  localparam logic [PW-1:0] ANCHOR  = PW'(DICT_SIZE);
  localparam logic [PW-1:0] NIL     = '0;

  logic [1:0]    mode_q;
  logic [PW-1:0] x_q, y_q, c_q, a_q, cnt_q;
  logic [IW-1:0] i_q, best_q;
  logic          ge_q, sub_q;
  logic [AW-1:0] last_q;
  logic [7:0]    byte_q;
  logic          mvalid_q;
  logic [4:0]    mlen_q;
  logic [AW-1:0] mpos_q;

  logic [PW-1:0] lp, ll, lr;
  logic [7:0]    da, db;
  logic          l_re, d_re;
  logic [PW-1:0] l_ra;
  logic          p_we, lw_we, rw_we, d_we;
  logic [PW-1:0] p_wa, p_wd, lw_wa, lw_wd, rw_wa, rw_wd;
  logic [AW-1:0] d_wa;
  logic [7:0]    d_wd;
  logic [IW-1:0] inext;
  logic [AW-1:0] da_ra, db_ra;
  logic [PW-1:0] old_n, slot, pos_w;
  logic          neq, cmp_done, upd, full, slot_zero, cnt_end, pred_more, out_busy;

  assign pos_w     = PW'(AW'(position_i));
  assign old_n     = sub_q ? y_q : x_q;
  assign neq       = (da != db);
  assign cmp_done  = neq || (i_q == IW'(MATCH_MAX - 1));
  assign upd       = (i_q >= best_q);
  assign full      = upd && (i_q == IW'(MATCH_MAX));
  assign slot      = ge_q ? lr : ll;
  assign slot_zero = (slot == NIL);
  assign cnt_end   = (cnt_q == PW'(DICT_SIZE));
  assign pred_more = (lr != NIL) && (cnt_q <= PW'(DICT_SIZE));
  assign out_busy  = mvalid_q && !m_tready_i;
  assign inext     = (cmd_i.uop == lzss_pkg::ST_CCMP) ? IW'(i_q + 1'b1) : i_q;
  assign da_ra     = AW'(y_q) + AW'(inext);
  assign db_ra     = AW'(x_q) + AW'(inext);

  assign st_o.mode      = mode_q;
  assign st_o.y_zero    = (y_q == NIL);
  assign st_o.cmp_done  = cmp_done;
  assign st_o.full      = full;
  assign st_o.slot_zero = slot_zero;
  assign st_o.cnt_end   = cnt_end;
  assign st_o.lp_zero   = (lp == NIL);
  assign st_o.ll_zero   = (ll == NIL);
  assign st_o.lr_zero   = (lr == NIL);
  assign st_o.sub       = sub_q;
  assign st_o.pred_more = pred_more;
  assign st_o.out_busy  = out_busy;

  assign m_tvalid_o       = mvalid_q;
  assign match_length_o   = mlen_q;
  assign match_position_o = 13'(mpos_q);

  always_comb begin
    l_re  = 1'b0;
    l_ra  = x_q;
    d_re  = 1'b0;
    p_we  = 1'b0; p_wa  = x_q; p_wd  = NIL;
    lw_we = 1'b0; lw_wa = x_q; lw_wd = NIL;
    rw_we = 1'b0; rw_wa = x_q; rw_wd = NIL;
    d_we  = 1'b0; d_wa  = AW'(y_q); d_wd = byte_q;
    case (cmd_i.uop)
      lzss_pkg::ST_CLR: begin
        p_we = 1'b1;  p_wa = cnt_q;
        lw_we = 1'b1; lw_wa = cnt_q;
        rw_we = 1'b1; rw_wa = cnt_q;
        d_we = 1'b1;  d_wa = cnt_q[AW-1:0]; d_wd = 8'd0;
      end
      lzss_pkg::ST_WRB: d_we = 1'b1;
      lzss_pkg::ST_ROOTA: begin
        rw_we = 1'b1; rw_wa = ANCHOR; rw_wd = y_q;
        p_we = 1'b1;  p_wa = y_q; p_wd = ANCHOR;
        lw_we = 1'b1; lw_wa = y_q;
      end
      lzss_pkg::ST_ROOTB: begin
        rw_we = 1'b1; rw_wa = y_q;
      end
      lzss_pkg::ST_INS0: begin
        l_re = 1'b1; l_ra = ANCHOR;
      end
      lzss_pkg::ST_CRD: begin
        l_re = 1'b1; l_ra = x_q; d_re = 1'b1;
      end
      lzss_pkg::ST_CCMP: d_re = !cmp_done;
      lzss_pkg::ST_LNKA: begin
        p_we = 1'b1; p_wa = y_q; p_wd = x_q;
        if (ge_q) begin
          rw_we = 1'b1; rw_wa = x_q; rw_wd = y_q;
          lw_we = 1'b1; lw_wa = y_q;
        end else begin
          lw_we = 1'b1; lw_wa = x_q; lw_wd = y_q;
          rw_we = 1'b1; rw_wa = y_q;
        end
      end
      lzss_pkg::ST_LNKB: begin
        if (ge_q) begin
          rw_we = 1'b1; rw_wa = y_q;
        end else begin
          lw_we = 1'b1; lw_wa = y_q;
        end
      end
      lzss_pkg::ST_P0, lzss_pkg::ST_P3: begin
        l_re = 1'b1; l_ra = x_q;
      end
      lzss_pkg::ST_P1: begin
        l_re = 1'b1; l_ra = lp;
      end
      lzss_pkg::ST_P2: begin
        if (ll == x_q) begin
          lw_we = 1'b1; lw_wa = a_q; lw_wd = y_q;
        end else begin
          rw_we = 1'b1; rw_wa = a_q; rw_wd = y_q;
        end
      end
      lzss_pkg::ST_P4: begin
        p_we = 1'b1;  p_wa = y_q;  p_wd = lp;
        lw_we = 1'b1; lw_wa = y_q; lw_wd = ll;
        rw_we = 1'b1; rw_wa = y_q; rw_wd = lr;
      end
      lzss_pkg::ST_P5: begin
        p_we = 1'b1; p_wa = c_q; p_wd = y_q;
      end
      lzss_pkg::ST_P6: begin
        p_we = 1'b1; p_wa = a_q; p_wd = y_q;
      end
      lzss_pkg::ST_P7: begin
        p_we = 1'b1; p_wa = x_q;
      end
      lzss_pkg::ST_DEL0: begin
        l_re = 1'b1; l_ra = old_n;
      end
      lzss_pkg::ST_S1: begin
        p_we = 1'b1; p_wa = c_q; p_wd = lp;
        l_re = 1'b1; l_ra = lp;
      end
      lzss_pkg::ST_S2: begin
        if (lr == old_n) begin
          rw_we = 1'b1; rw_wa = a_q; rw_wd = c_q;
        end else begin
          lw_we = 1'b1; lw_wa = a_q; lw_wd = c_q;
        end
      end
      lzss_pkg::ST_S3: begin
        p_we = 1'b1; p_wa = old_n;
      end
      lzss_pkg::ST_Q0: begin
        l_re = 1'b1; l_ra = ll;
      end
      lzss_pkg::ST_Q1: begin
        l_re = pred_more; l_ra = lr;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      mode_q   <= lzss_pkg::MODE_WRITE;
      last_q   <= '0;
      mvalid_q <= 1'b0;
    end else begin
      if ((cmd_i.uop == lzss_pkg::ST_DONE) && !out_busy) mvalid_q <= 1'b1;
      else if (m_tready_i) mvalid_q <= 1'b0;
      if (cmd_i.load) mode_q <= mode_i;
      case (cmd_i.uop)
        lzss_pkg::ST_CLR:   cnt_q <= cnt_q + 1'b1;
        lzss_pkg::ST_INS1:  cnt_q <= '0;
        lzss_pkg::ST_CEVAL: begin
          if (upd) last_q <= x_q[AW-1:0];
          if (!full && !slot_zero) cnt_q <= cnt_q + 1'b1;
        end
        lzss_pkg::ST_Q0:    cnt_q <= '0;
        lzss_pkg::ST_Q1:    if (pred_more) cnt_q <= cnt_q + 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q    <= pos_w;
      y_q    <= pos_w;
      byte_q <= byte_value_i;
      best_q <= '0;
      sub_q  <= 1'b0;
    end
    case (cmd_i.uop)
      lzss_pkg::ST_INS1: begin
        x_q <= lr;
        i_q <= '0;
      end
      lzss_pkg::ST_CCMP: begin
        if (neq) begin
          ge_q <= (da > db);
        end else if (cmp_done) begin
          i_q  <= IW'(MATCH_MAX);
          ge_q <= 1'b1;
        end else begin
          i_q <= inext;
        end
      end
      lzss_pkg::ST_CEVAL: begin
        if (upd) best_q <= i_q;
        if (!full && !slot_zero) begin
          x_q <= slot;
          i_q <= '0;
        end
      end
      lzss_pkg::ST_P1:   a_q <= lp;
      lzss_pkg::ST_P4: begin
        c_q <= ll;
        a_q <= lr;
      end
      lzss_pkg::ST_DEL1: c_q <= (lr == NIL) ? ll : lr;
      lzss_pkg::ST_S1:   a_q <= lp;
      lzss_pkg::ST_Q0:   c_q <= ll;
      lzss_pkg::ST_Q1: begin
        if (pred_more) begin
          c_q <= lr;
        end else begin
          y_q   <= c_q;
          sub_q <= 1'b1;
        end
      end
      lzss_pkg::ST_DONE: begin
        if (!out_busy) begin
          mlen_q <= (mode_q == lzss_pkg::MODE_INSERT) ? 5'(best_q) : 5'd0;
          mpos_q <= last_q;
        end
      end
      default: ;
    endcase
  end

  lzss_ram #(.WIDTH(PW), .DEPTH(DICT_SIZE + 1)) u_par (
    .clk_i, .we_i(p_we), .waddr_i(p_wa), .wdata_i(p_wd),
    .re_i(l_re), .raddr_i(l_ra), .rdata_o(lp)
  );

  lzss_ram #(.WIDTH(PW), .DEPTH(DICT_SIZE + 1)) u_lft (
    .clk_i, .we_i(lw_we), .waddr_i(lw_wa), .wdata_i(lw_wd),
    .re_i(l_re), .raddr_i(l_ra), .rdata_o(ll)
  );

  lzss_ram #(.WIDTH(PW), .DEPTH(DICT_SIZE + 1)) u_rgt (
    .clk_i, .we_i(rw_we), .waddr_i(rw_wa), .wdata_i(rw_wd),
    .re_i(l_re), .raddr_i(l_ra), .rdata_o(lr)
  );

  lzss_ram #(.WIDTH(8), .DEPTH(DICT_SIZE)) u_dict_a (
    .clk_i, .we_i(d_we), .waddr_i(d_wa), .wdata_i(d_wd),
    .re_i(d_re), .raddr_i(da_ra), .rdata_o(da)
  );

  lzss_ram #(.WIDTH(8), .DEPTH(DICT_SIZE)) u_dict_b (
    .clk_i, .we_i(d_we), .waddr_i(d_wa), .wdata_i(d_wd),
    .re_i(d_re), .raddr_i(db_ra), .rdata_o(db)
  );

endmodule
`default_nettype wire

// File: tb/lzss_tree_match_finder_tb.sv
`timescale 1ns / 1ps
module lzss_tree_match_finder_tb;

  localparam int unsigned DSZ = 8192;
  localparam int unsigned ANCHOR = DSZ;
  localparam int unsigned MAXLEN = 18;
  localparam int unsigned STALL_LIMIT = 1000000;

  typedef struct packed {
    logic [1:0]  mode;
    logic [12:0] pos;
    logic [7:0]  val;
  } req_t;

  typedef struct packed {
    logic [4:0]  len;
    logic [12:0] pos;
  } match_t;

  logic        clk_i, rst_ni;
  logic        s_tvalid, m_tready;
  logic [23:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        s_tready_o, m_tvalid_o;
  logic [23:0] m_tdata_o;

  lzss_tree_match_finder uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_tvalid_i(s_tvalid), .s_tready_o(s_tready_o),
    .s_tdata_i(s_tdata), .s_tuser_i(s_tuser),
    .m_tvalid_o(m_tvalid_o), .m_tready_i(m_tready), .m_tdata_o(m_tdata_o)
  );

  logic [7:0]  dict_mem [DSZ];
  int unsigned parent_of [DSZ+1];
  int unsigned left_of [DSZ+1];
  int unsigned right_of [DSZ+1];
  logic [12:0] last_pos;

  req_t   pending [$];
  match_t match_queue [$];
  int     total_reqs, sent_cnt, recv_cnt, err_cnt;
  int     n_ins, n_del, n_full, n_hits;
  int     stall_cnt, hold_left;
  bit     hold_done;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic void replace_node(int unsigned old_n, int unsigned new_n);
    int unsigned par;
    par = parent_of[old_n];
    if (left_of[par] == old_n) left_of[par] = new_n;
    else right_of[par] = new_n;
    parent_of[new_n] = parent_of[old_n];
    left_of[new_n] = left_of[old_n];
    right_of[new_n] = right_of[old_n];
    parent_of[left_of[new_n]] = new_n;
    parent_of[right_of[new_n]] = new_n;
    parent_of[old_n] = 0;
  endfunction

  function automatic void splice(int unsigned old_n, int unsigned child);
    int unsigned par;
    par = parent_of[old_n];
    parent_of[child] = par;
    if (right_of[par] == old_n) right_of[par] = child;
    else left_of[par] = child;
    parent_of[old_n] = 0;
  endfunction

  function automatic void unlink_pos(int unsigned p, bit top);
    int unsigned nx, steps;
    if (parent_of[p] == 0) return;
    if (right_of[p] == 0) splice(p, left_of[p]);
    else if (left_of[p] == 0) splice(p, right_of[p]);
    else if (top) begin
      nx = left_of[p];
      steps = 0;
      while (right_of[nx] != 0 && steps <= DSZ) begin
        nx = right_of[nx];
        steps++;
      end
      unlink_pos(nx, 1'b0);
      replace_node(p, nx);
    end
  endfunction

  function automatic int unsigned find_match(int unsigned nn);
    int unsigned test, best, i;
    int diff;
    test = right_of[ANCHOR];
    best = 0;
    if (nn == 0) return 0;
    for (int unsigned walked = 0; walked <= DSZ; walked++) begin
      diff = 0;
      for (i = 0; i < MAXLEN; i++) begin
        diff = int'(dict_mem[(nn + i) % DSZ]) - int'(dict_mem[(test + i) % DSZ]);
        if (diff != 0) break;
      end
      if (i >= best) begin
        best = i;
        last_pos = test[12:0];
        if (best >= MAXLEN) begin
          replace_node(test, nn);
          return best;
        end
      end
      if (diff >= 0) begin
        if (right_of[test] == 0) begin
          right_of[test] = nn;
          parent_of[nn] = test; right_of[nn] = 0; left_of[nn] = 0;
          return best;
        end
        test = right_of[test];
      end else begin
        if (left_of[test] == 0) begin
          left_of[test] = nn;
          parent_of[nn] = test; right_of[nn] = 0; left_of[nn] = 0;
          return best;
        end
        test = left_of[test];
      end
    end
    return best;
  endfunction

  function automatic match_t apply_req(req_t r);
    match_t res;
    int unsigned len;
    len = 0;
    case (r.mode)
      lzss_pkg::MODE_WRITE: dict_mem[r.pos] = r.val;
      lzss_pkg::MODE_ROOT: begin
        right_of[ANCHOR] = r.pos;
        parent_of[r.pos] = ANCHOR;
        right_of[r.pos] = 0;
        left_of[r.pos] = 0;
      end
      lzss_pkg::MODE_INSERT: begin
        len = find_match(r.pos);
        n_ins++;
        if (len >= MAXLEN) n_full++;
        if (len > 0) n_hits++;
      end
      default: begin
        unlink_pos(r.pos, 1'b1);
        n_del++;
      end
    endcase
    res.len = len[4:0];
    res.pos = last_pos;
    return res;
  endfunction

  task automatic add_req(logic [1:0] mode, int unsigned pos, logic [7:0] val);
    req_t r;
    r.mode = mode;
    r.pos = pos[12:0];
    r.val = val;
    pending.push_back(r);
  endtask

  task automatic report(string what, logic [31:0] exp_v, logic [31:0] got_v);
    err_cnt++;
    if (err_cnt <= 10)
      $display("mismatch %0s at result %0d: expected %0d, got %0d", what, recv_cnt, exp_v, got_v);
  endtask

  function automatic bit idle_allowed(int cnt);
    return !(cnt >= 500 && cnt < 700);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
      s_tuser <= lzss_pkg::MODE_WRITE;
    end else begin
      if (s_tvalid && s_tready_o) begin
        match_queue.push_back(apply_req(req_t'{s_tuser, s_tdata[12:0], s_tdata[20:13]}));
        sent_cnt++;
      end
      if (!s_tvalid || s_tready_o) begin
        if (pending.size() > 0 &&
            !(idle_allowed(sent_cnt) && $urandom_range(0, 99) < 29)) begin
          req_t r;
          r = pending.pop_front();
          s_tvalid <= 1'b1;
          s_tuser <= r.mode;
          s_tdata <= {3'b000, r.val, r.pos};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid_o && m_tready) begin
        if (match_queue.size() == 0) begin
          report("unexpected result", 32'd0, 32'(m_tdata_o));
        end else begin
          match_t e;
          e = match_queue.pop_front();
          if (m_tdata_o[4:0] !== e.len)
            report("match_length", 32'(e.len), 32'(m_tdata_o[4:0]));
          if (m_tdata_o[17:5] !== e.pos)
            report("match_position", 32'(e.pos), 32'(m_tdata_o[17:5]));
        end
        recv_cnt++;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (!hold_done && recv_cnt == 300) begin
        hold_done = 1'b1;
        hold_left = 250;
        m_tready <= 1'b0;
      end else begin
        m_tready <= !idle_allowed(recv_cnt) || $urandom_range(0, 99) >= 29;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_tvalid && s_tready_o) || (m_tvalid_o && m_tready)) stall_cnt = 0;
      else stall_cnt++;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    int unsigned b, n, alpha;
    logic [7:0] base;
    for (int k = 0; k < DSZ; k++) begin
      dict_mem[k] = 8'h00;
      parent_of[k] = 0; left_of[k] = 0; right_of[k] = 0;
    end
    parent_of[ANCHOR] = 0; left_of[ANCHOR] = 0; right_of[ANCHOR] = 0;
    last_pos = '0;
    rst_ni = 1'b0;

    // directed corner cases
    add_req(lzss_pkg::MODE_INSERT, 0, 8'hFF);
    add_req(lzss_pkg::MODE_DELETE, 7, 8'h00);
    add_req(lzss_pkg::MODE_WRITE, 8191, 8'hFF);
    add_req(lzss_pkg::MODE_WRITE, 0, 8'h00);
    add_req(lzss_pkg::MODE_WRITE, 1, 8'hFF);
    add_req(lzss_pkg::MODE_WRITE, 2, 8'hAA);
    add_req(lzss_pkg::MODE_ROOT, 8191, 8'h55);
    add_req(lzss_pkg::MODE_INSERT, 3, 8'h00);
    add_req(lzss_pkg::MODE_INSERT, 8190, 8'h00);
    add_req(lzss_pkg::MODE_INSERT, 100, 8'h00);
    add_req(lzss_pkg::MODE_INSERT, 200, 8'h00);
    add_req(lzss_pkg::MODE_INSERT, 200, 8'h00);
    add_req(lzss_pkg::MODE_INSERT, 300, 8'h00);
    add_req(lzss_pkg::MODE_DELETE, 8191, 8'h00);
    add_req(lzss_pkg::MODE_DELETE, 200, 8'h00);
    add_req(lzss_pkg::MODE_DELETE, 4000, 8'h00);
    add_req(lzss_pkg::MODE_ROOT, 0, 8'h00);
    add_req(lzss_pkg::MODE_INSERT, 8191, 8'h00);
    add_req(lzss_pkg::MODE_INSERT, 0, 8'h00);
    add_req(lzss_pkg::MODE_DELETE, 0, 8'h00);

    // random encoder-like runs: fill a window, root it, insert and drop positions
    while (pending.size() < 1150) begin
      b = ($urandom_range(0, 7) == 0) ? 8191 - $urandom_range(0, 10) : $urandom_range(0, 8191);
      n = $urandom_range(8, 30);
      alpha = $urandom_range(1, 3);
      base = 8'($urandom);
      for (int unsigned k = 0; k < n + MAXLEN; k++)
        add_req(lzss_pkg::MODE_WRITE, (b + k) % DSZ, base ^ 8'($urandom_range(0, alpha)));
      add_req(lzss_pkg::MODE_ROOT, b, 8'($urandom));
      for (int unsigned k = 1; k <= n; k++) begin
        add_req(lzss_pkg::MODE_INSERT, (b + k) % DSZ, 8'($urandom));
        if ($urandom_range(0, 5) == 0)
          add_req(lzss_pkg::MODE_DELETE, (b + $urandom_range(0, k)) % DSZ, 8'($urandom));
        if ($urandom_range(0, 29) == 0)
          add_req(2'($urandom_range(0, 3)), $urandom_range(0, 8191), 8'($urandom));
      end
    end
    total_reqs = pending.size();

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (!(sent_cnt == total_reqs && match_queue.size() == 0)) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    $display("%0d requests: %0d inserts (%0d matched, %0d full length), %0d deletes",
             total_reqs, n_ins, n_hits, n_full, n_del);
    $display("%0d results checked, %0d mismatches", recv_cnt, err_cnt);
    if (err_cnt == 0 && match_queue.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
